@@ rtl/wlw_pkg.sv @@
// Shared types, constants and escape tables for the weighted line wrapper.
// Used by the output packer and the top level; depends on nothing.
`default_nettype none
package wlw_pkg;

  localparam int LINE_BYTES = 200;
  localparam int TOP_WEIGHT = 20;
  localparam int NUM_SLOTS  = TOP_WEIGHT + 1;
  localparam int LIMIT_MAX  = LINE_BYTES - 2;

  // Line store address and fill count: the fill can reach LINE_BYTES + 1.
  localparam int POS_W = $clog2(LINE_BYTES + 2);

  // Bytes sent per item are capped at 512 (64 results of eight bytes).
  localparam int TOT_W = 10;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    CMD_CHAR  = 2'd0,
    CMD_HINT  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LIMIT   = 3'd0,
    REG_ESCAPE  = 3'd1,
    REG_NBSP    = 3'd2,
    REG_ENSP    = 3'd3,
    REG_SHY     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_NBSP = 2'd1,
    ESC_ENSP = 2'd2,
    ESC_SHY  = 2'd3
  } esc_t;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [4:0] W_SPACE    = 5'd3;
  localparam logic [4:0] W_COMMA    = 5'd6;
  localparam logic [4:0] W_SEMI     = 5'd7;
  localparam logic [4:0] W_COLON    = 5'd8;
  localparam logic [4:0] W_DOT      = 5'd9;
  localparam logic [4:0] W_TEXT_ADD = 5'd10;

  // Request from the sequencer to the output packer.
  typedef struct packed {
    logic       push;
    logic       finish;
    logic [7:0] data;
  } pack_req_t;

  typedef struct packed {
    logic can_push;
    logic fin_ok;
  } pack_sts_t;

  // Index of the last character of an escape reference.
  function automatic logic [2:0] esc_last(input esc_t kind);
    logic [2:0] r;
    case (kind)
      ESC_ENSP: r = 3'd7;
      default:  r = 3'd5;
    endcase
    return r;
  endfunction

  // Characters of "&#xA0;", "&#x2002;" and "&#xAD;".
  function automatic logic [7:0] esc_char(input esc_t kind, input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0: c = 8'h26;
      3'd1: c = 8'h23;
      3'd2: c = 8'h78;
      3'd3: c = (kind == ESC_ENSP) ? 8'h32 : 8'h41;
      3'd4: c = (kind == ESC_ENSP) ? 8'h30 :
                (kind == ESC_SHY)  ? 8'h44 : 8'h30;
      3'd5: c = (kind == ESC_ENSP) ? 8'h30 : 8'h3B;
      3'd6: c = 8'h32;
      3'd7: c = 8'h3B;
      default: c = 8'h3B;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/wlw_pack.sv @@
// Output packer: gathers bytes up to eight to a result and holds the output register.
// Depends on wlw_pkg for the request and status structs.
`default_nettype none
module wlw_pack (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wlw_pkg::pack_req_t req,
  output wlw_pkg::pack_sts_t      sts,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [63:0]             out_bytes,
  output logic [3:0]              byte_count,
  output logic                    last
);
  import wlw_pkg::*;

  logic [63:0] acc;
  logic [3:0]  cnt;
  logic        out_free;
  logic        load_mid;
  logic        load_end;

  assign out_free     = !out_valid || !out_stall;
  assign sts.can_push = (cnt != 4'd8) || out_free;
  assign sts.fin_ok   = (cnt == 4'd0) || out_free;
  assign load_mid     = req.push && (cnt == 4'd8) && out_free;
  assign load_end     = req.finish && (cnt != 4'd0) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= 4'd0;
    end else begin
      if (load_mid || load_end) begin
        out_valid  <= 1'b1;
        out_bytes  <= acc;
        byte_count <= cnt;
        last       <= load_end;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load_end) begin
        cnt <= 4'd0;
      end else if (req.push && sts.can_push) begin
        if (cnt == 4'd8) begin
          acc <= {56'd0, req.data};
          cnt <= 4'd1;
        end else if (cnt == 4'd0) begin
          acc <= {56'd0, req.data};
          cnt <= 4'd1;
        end else begin
          acc <= acc | ({56'd0, req.data} << {cnt[2:0], 3'b000});
          cnt <= cnt + 4'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/weighted_line_wrapper.sv @@
// Top level of the weighted line wrapper: sequencer, line store and break slots.
// Depends on wlw_pkg and instantiates wlw_pack.
`default_nettype none
// The block takes one item at a time and stalls its input until every result of
// that item has gone into the packer. A space or tab passes through the extra
// state S_SPACE for the read of the character before it. A flush or a cut reads
// the line store one byte per cycle while the packer can take bytes, and each
// escape character repeats the character sequence. The line store's single read
// port sets this pace. A break hint is taken in the idle state, and a
// configuration write is always accepted. Results leave through an output
// register, so the next item can start while one waits.
module weighted_line_wrapper (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  char_code,
  input  wire logic [4:0]  break_weight,
  input  wire logic        drop_break_char,
  input  wire logic        preformatted,
  input  wire logic        in_attr_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_bytes,
  output logic [3:0]       byte_count,
  output logic             last
);
  import wlw_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHAR   = 10'b0000000010,
    S_SPACE  = 10'b0000000100,
    S_CHECK  = 10'b0000001000,
    S_EMIT   = 10'b0000010000,
    S_NL     = 10'b0000100000,
    S_MOVE   = 10'b0001000000,
    S_REBASE = 10'b0010000000,
    S_NEXT   = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    POST_FLUSH = 2'd0,
    POST_NOBRK = 2'd1,
    POST_CUT   = 2'd2
  } post_t;

  state_t state;
  post_t  post;

  logic [7:0] line_limit;
  logic       escape_enable;
  logic [4:0] nbsp_code;
  logic [4:0] en_space_code;
  logic [4:0] soft_hyphen_code;

  logic [7:0] line_store [0:LINE_BYTES];
  logic [7:0] rdata;
  logic       mem_we;
  logic       mem_re;
  pos_t       mem_wa;
  pos_t       mem_ra;
  logic [7:0] mem_wd;

  pos_t           fill;
  logic           overflowed;
  logic [4:0]     best;
  logic [NUM_SLOTS-1:0] bvalid;
  logic [NUM_SLOTS-1:0] bdrop;
  pos_t           bpos [NUM_SLOTS];

  logic [7:0] ch;
  esc_t       kind;
  logic [2:0] seq;
  logic       pre;
  logic       attr;
  pos_t       idx;
  pos_t       end_pos;
  pos_t       wa;
  pos_t       saved;
  logic       rd_pend;
  logic [TOT_W-1:0] tot;

  pack_req_t  preq;
  pack_sts_t  psts;

  logic       in_accept;
  esc_t       kind_in;
  logic [7:0] cur_c;
  logic       store_ok;
  logic       is_sp;
  pos_t       lim;
  logic       trig;
  pos_t       cut_pos;
  logic [POS_W:0] sv_sum;
  pos_t       sv;
  logic       can_push_eff;
  logic       consume;
  logic       issue;
  logic       emit_done;
  logic       move_done;
  logic [4:0] sp_w;

  logic       a_en;
  logic [4:0] a_w;
  logic       a_drop;
  pos_t       a_pos;

  logic [NUM_SLOTS-1:0] rb_keep;
  logic [4:0]           rb_best;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit       <= 8'd80;
      escape_enable    <= 1'b0;
      nbsp_code        <= 5'd1;
      en_space_code    <= 5'd2;
      soft_hyphen_code <= 5'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LIMIT:  line_limit       <= cfg_data;
        REG_ESCAPE: escape_enable    <= cfg_data[0];
        REG_NBSP:   nbsp_code        <= cfg_data[4:0];
        REG_ENSP:   en_space_code    <= cfg_data[4:0];
        REG_SHY:    soft_hyphen_code <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Line store: one write and one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= line_store[mem_ra];
    end
  end

  always_comb begin
    kind_in = ESC_NONE;
    if (escape_enable && (char_code[7:5] == 3'd0)) begin
      if (char_code[4:0] == nbsp_code) begin
        kind_in = ESC_NBSP;
      end else if (char_code[4:0] == en_space_code) begin
        kind_in = ESC_ENSP;
      end else if (char_code[4:0] == soft_hyphen_code) begin
        kind_in = ESC_SHY;
      end
    end
  end

  assign cur_c    = (kind == ESC_NONE) ? ch : esc_char(kind, seq);
  assign store_ok = (fill <= POS_W'(LINE_BYTES));
  assign is_sp    = !pre && ((cur_c == CH_SPACE) || (cur_c == CH_TAB));

  always_comb begin
    lim = POS_W'(line_limit);
    if (line_limit == 8'd0) begin
      lim = POS_W'(1);
    end else if (POS_W'(line_limit) > POS_W'(LIMIT_MAX)) begin
      lim = POS_W'(LIMIT_MAX);
    end
  end

  assign trig = (fill >= lim) || (overflowed && (best != 5'd0));

  always_comb begin
    cut_pos = (bpos[best] > fill) ? fill : bpos[best];
    sv_sum  = {1'b0, cut_pos} + {{POS_W{1'b0}}, bdrop[best]};
    sv      = (sv_sum > {1'b0, fill}) ? fill : sv_sum[POS_W-1:0];
  end

  // Weight of a space: by the character before it, plus the text bonus if !attr.
  always_comb begin
    sp_w = W_SPACE;
    if (fill > POS_W'(1)) begin
      case (rdata)
        CH_COMMA: sp_w = W_COMMA;
        CH_SEMI:  sp_w = W_SEMI;
        CH_COLON: sp_w = W_COLON;
        CH_DOT:   sp_w = W_DOT;
        default:  sp_w = W_SPACE;
      endcase
      if (!attr) begin
        sp_w = sp_w + W_TEXT_ADD;
      end
    end
  end

  always_comb begin
    a_en   = 1'b0;
    a_w    = break_weight;
    a_drop = drop_break_char;
    if (state == S_SPACE) begin
      a_en   = 1'b1;
      a_w    = sp_w;
      a_drop = 1'b1;
    end else if (in_accept && (command == CMD_HINT)) begin
      a_en = 1'b1;
    end
    if (fill == POS_W'(0)) begin
      a_drop = 1'b0;
    end
    a_pos = a_drop ? (fill - POS_W'(1)) : fill;
  end

  // Rebase: every valid slot past saved survives, the highest becomes the best.
  always_comb begin
    rb_best = 5'd0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rb_keep[i] = bvalid[i] && (bpos[i] > saved);
      if (rb_keep[i]) begin
        rb_best = 5'(i);
      end
    end
  end

  assign can_push_eff = tot[TOT_W-1] || psts.can_push;
  assign consume      = rd_pend && can_push_eff;
  assign emit_done    = (idx == end_pos) && !rd_pend;
  assign move_done    = (idx == fill) && !rd_pend;

  always_comb begin
    issue = 1'b0;
    if (state == S_EMIT) begin
      issue = (idx != end_pos) && (!rd_pend || consume);
    end else if (state == S_MOVE) begin
      issue = (idx != fill);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = fill;
    mem_wd = cur_c;
    mem_re = 1'b0;
    mem_ra = idx;
    preq   = '0;
    case (state)
      S_CHAR: begin
        mem_we = store_ok;
        mem_re = store_ok && is_sp && (fill != POS_W'(0));
        mem_ra = fill - POS_W'(1);
      end
      S_EMIT: begin
        mem_re    = issue;
        preq.push = rd_pend && !tot[TOT_W-1];
        preq.data = rdata;
      end
      S_NL: begin
        preq.push = !tot[TOT_W-1];
        preq.data = CH_NL;
      end
      S_MOVE: begin
        mem_re = issue;
        mem_we = rd_pend;
        mem_wa = wa;
        mem_wd = rdata;
      end
      S_FIN: begin
        preq.finish = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      overflowed <= 1'b0;
      best       <= 5'd0;
      bvalid     <= NUM_SLOTS'(1);
      bdrop      <= '0;
      rd_pend    <= 1'b0;
      kind       <= ESC_NONE;
      tot        <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        bpos[i] <= '0;
      end
    end else begin
      if (preq.push && psts.can_push) begin
        tot <= tot + TOT_W'(1);
      end
      if (a_en && (a_w <= 5'(TOP_WEIGHT))) begin
        bpos[a_w]   <= a_pos;
        bvalid[a_w] <= 1'b1;
        bdrop[a_w]  <= a_drop;
        if ((a_w >= best) && (overflowed || (a_pos != POS_W'(0)))) begin
          best <= a_w;
        end
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            tot <= '0;
            case (command)
              CMD_CHAR: begin
                ch    <= char_code;
                kind  <= kind_in;
                seq   <= 3'd0;
                pre   <= preformatted;
                attr  <= in_attr_value;
                state <= S_CHAR;
              end
              CMD_FLUSH: begin
                kind    <= ESC_NONE;
                idx     <= '0;
                end_pos <= fill;
                post    <= POST_FLUSH;
                rd_pend <= 1'b0;
                state   <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_CHAR: begin
          if (!store_ok) begin
            state <= S_NEXT;
          end else begin
            fill <= fill + POS_W'(1);
            if (cur_c == CH_NL) begin
              idx     <= '0;
              end_pos <= fill + POS_W'(1);
              post    <= POST_FLUSH;
              rd_pend <= 1'b0;
              state   <= S_EMIT;
            end else if (is_sp) begin
              state <= S_SPACE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_SPACE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!trig) begin
            state <= S_NEXT;
          end else begin
            idx     <= '0;
            rd_pend <= 1'b0;
            state   <= S_EMIT;
            if ((best != 5'd0) && bvalid[best]) begin
              end_pos <= cut_pos;
              saved   <= sv;
              post    <= POST_CUT;
            end else begin
              end_pos <= (fill < lim) ? fill : lim;
              post    <= POST_NOBRK;
            end
          end
        end
        S_EMIT: begin
          if (issue) begin
            idx     <= idx + POS_W'(1);
            rd_pend <= 1'b1;
          end else if (consume) begin
            rd_pend <= 1'b0;
          end
          if (emit_done) begin
            case (post)
              POST_CUT: state <= S_NL;
              POST_NOBRK: begin
                fill       <= '0;
                bvalid     <= '0;
                best       <= 5'd0;
                overflowed <= 1'b1;
                state      <= S_NEXT;
              end
              default: begin
                fill     <= '0;
                bvalid   <= '0;
                best     <= 5'd0;
                bdrop[0] <= 1'b0;
                state    <= S_NEXT;
              end
            endcase
          end
        end
        S_NL: begin
          if (can_push_eff) begin
            if ((saved != POS_W'(0)) && (saved < fill)) begin
              idx     <= saved;
              wa      <= '0;
              rd_pend <= 1'b0;
              state   <= S_MOVE;
            end else begin
              state <= S_REBASE;
            end
          end
        end
        S_MOVE: begin
          if (rd_pend) begin
            wa <= wa + POS_W'(1);
          end
          if (issue) begin
            idx <= idx + POS_W'(1);
          end
          rd_pend <= issue;
          if (move_done) begin
            state <= S_REBASE;
          end
        end
        S_REBASE: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (rb_keep[i]) begin
              bpos[i] <= bpos[i] - saved;
            end
          end
          bvalid     <= rb_keep;
          best       <= rb_best;
          bdrop[0]   <= 1'b0;
          fill       <= fill - saved;
          overflowed <= 1'b0;
          state      <= S_NEXT;
        end
        S_NEXT: begin
          if ((kind != ESC_NONE) && (seq != esc_last(kind))) begin
            seq   <= seq + 3'd1;
            state <= S_CHAR;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (psts.fin_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wlw_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .req        (preq),
    .sts        (psts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bytes  (out_bytes),
    .byte_count (byte_count),
    .last       (last)
  );

endmodule
`default_nettype wire

@@ test/weighted_line_wrapper_test.sv @@
// Self-checking testbench for the weighted line wrapper: it drives characters,
// break hints and flushes under several register settings and random idling,
// and checks every packed result against its own model. Depends on wlw_pkg.
`default_nettype none
module weighted_line_wrapper_test;
  import wlw_pkg::*;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic [4:0] break_weight;
    logic       drop_break_char;
    logic       preformatted;
    logic       in_attr_value;
  } text_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last;
  } packed_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic [7:0] char_code = '0;
  logic [4:0] break_weight = '0;
  logic drop_break_char = 1'b0;
  logic preformatted = 1'b0;
  logic in_attr_value = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_bytes;
  logic [3:0] byte_count;
  logic last;

  weighted_line_wrapper u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .char_code(char_code), .break_weight(break_weight),
    .drop_break_char(drop_break_char), .preformatted(preformatted),
    .in_attr_value(in_attr_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_bytes(out_bytes),
    .byte_count(byte_count), .last(last)
  );

  always #4 clk = ~clk;

  // Model state.
  logic [7:0] m_limit, m_nbsp, m_ensp, m_shy;
  logic m_escape;
  logic [7:0] m_line [0:LINE_BYTES];
  int m_fill;
  int m_pos [0:NUM_SLOTS-1];
  bit m_valid [0:NUM_SLOTS-1];
  bit m_drop [0:NUM_SLOTS-1];
  int m_best;
  bit m_over;
  logic [7:0] sent [$];

  text_item_t pending_items [$];
  packed_word_t expected_words [$];
  int failures = 0;
  bit quiet = 1'b0;
  bit hold_input = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;

  function automatic void model_reset();
    m_limit = 8'd80; m_escape = 1'b0; m_nbsp = 8'd1; m_ensp = 8'd2; m_shy = 8'd7;
    for (int i = 0; i <= LINE_BYTES; i++) m_line[i] = '0;
    m_fill = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      m_valid[i] = 0; m_pos[i] = 0; m_drop[i] = 0;
    end
    m_valid[0] = 1; m_best = 0; m_over = 0;
  endfunction

  function automatic void send_line(int n);
    for (int i = 0; i < n && i <= LINE_BYTES; i++) sent.push_back(m_line[i]);
  endfunction

  function automatic void clear_slots();
    for (int i = 0; i < NUM_SLOTS; i++) m_valid[i] = 0;
  endfunction

  function automatic void flush_line();
    send_line(m_fill);
    m_fill = 0; clear_slots(); m_best = 0; m_drop[0] = 0;
  endfunction

  function automatic void record_break(int w, bit drop);
    int p;
    if (w > TOP_WEIGHT) return;
    if (drop && m_fill == 0) drop = 0;
    p = drop ? m_fill - 1 : m_fill;
    m_pos[w] = p; m_valid[w] = 1; m_drop[w] = drop;
    if (w >= m_best && (m_over || p > 0)) m_best = w;
  endfunction

  function automatic void try_cut();
    int lim, p, keep;
    lim = (m_limit == 0) ? 1 : m_limit;
    if (lim > LIMIT_MAX) lim = LIMIT_MAX;
    if (!(m_fill >= lim || (m_over && m_best != 0))) return;
    if (m_best != 0 && m_valid[m_best]) begin
      p = m_pos[m_best];
      if (p > m_fill) p = m_fill;
      keep = p + (m_drop[m_best] ? 1 : 0);
      if (keep > m_fill) keep = m_fill;
      send_line(p);
      sent.push_back(CH_NL);
      for (int i = keep; i < m_fill; i++) m_line[i - keep] = m_line[i];
      m_best = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (m_valid[i] && m_pos[i] > keep) begin
          m_pos[i] -= keep; m_best = i;
        end else m_valid[i] = 0;
      end
      m_drop[0] = 0; m_fill -= keep; m_over = 0;
    end else begin
      send_line(m_fill < lim ? m_fill : lim);
      m_fill = 0; clear_slots(); m_best = 0; m_over = 1;
    end
  endfunction

  function automatic void store_char(logic [7:0] c, bit pre, bit attr);
    int w;
    logic [7:0] prev;
    if (m_fill > LINE_BYTES) return;
    m_line[m_fill] = c; m_fill++;
    if (c == CH_NL) begin
      flush_line();
      return;
    end
    if (!pre && (c == CH_SPACE || c == CH_TAB)) begin
      w = W_SPACE;
      if (m_fill > 1) begin
        prev = m_line[m_fill - 2];
        if (prev == CH_COMMA) w = W_COMMA;
        if (prev == CH_SEMI) w = W_SEMI;
        if (prev == CH_COLON) w = W_COLON;
        if (prev == CH_DOT) w = W_DOT;
        if (!attr) w += W_TEXT_ADD;
      end
      record_break(w, 1'b1);
    end
    try_cut();
  endfunction

  function automatic void store_ref(string s, bit pre, bit attr);
    for (int i = 0; i < s.len(); i++) store_char(s[i], pre, attr);
  endfunction

  function automatic void predict_words(text_item_t it);
    int n;
    packed_word_t pw;
    sent.delete();
    case (cmd_t'(it.command))
      CMD_CHAR: begin
        if (m_escape && it.char_code < 32 && it.char_code == m_nbsp)
          store_ref("&#xA0;", it.preformatted, it.in_attr_value);
        else if (m_escape && it.char_code < 32 && it.char_code == m_ensp)
          store_ref("&#x2002;", it.preformatted, it.in_attr_value);
        else if (m_escape && it.char_code < 32 && it.char_code == m_shy)
          store_ref("&#xAD;", it.preformatted, it.in_attr_value);
        else store_char(it.char_code, it.preformatted, it.in_attr_value);
      end
      CMD_HINT: record_break(it.break_weight, it.drop_break_char);
      CMD_FLUSH: flush_line();
      default: ;
    endcase
    n = (sent.size() + 7) / 8;
    if (n > 64) n = 64;
    for (int k = 0; k < n; k++) begin
      pw = '0;
      for (int i = 0; i < 8; i++)
        if (k * 8 + i < sent.size()) begin
          pw.out_bytes[8*i +: 8] = sent[k * 8 + i];
          pw.byte_count++;
        end
      pw.last = (k + 1 == n);
      expected_words.push_back(pw);
    end
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_words({command, char_code, break_weight,
                                   drop_break_char, preformatted, in_attr_value});
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0 && !hold_input) begin
        {command, char_code, break_weight, drop_break_char, preformatted,
         in_attr_value} <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and output stalls.
  always @(posedge clk) begin
    packed_word_t pw;
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result: out_bytes %h", out_bytes);
        failures++;
      end else begin
        pw = expected_words.pop_front();
        if (out_bytes !== pw.out_bytes) begin
          $error("out_bytes expected %h got %h", pw.out_bytes, out_bytes);
          failures++;
        end
        if (byte_count !== pw.byte_count) begin
          $error("byte_count expected %0d got %0d", pw.byte_count, byte_count);
          failures++;
        end
        if (last !== pw.last) begin
          $error("last expected %0d got %0d", pw.last, last);
          failures++;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(1, 7);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_item(int c, int ch, int w, int d, int pre, int attr);
    pending_items.push_back({c[1:0], ch[7:0], w[4:0], d[0], pre[0], attr[0]});
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(CMD_CHAR, s[i], 0, 0, 0, 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LIMIT: m_limit = value;
      REG_ESCAPE: m_escape = value[0];
      REG_NBSP: m_nbsp = value[4:0];
      REG_ENSP: m_ensp = value[4:0];
      REG_SHY: m_shy = value[4:0];
      default: ;
    endcase
  endtask

  // Waits until every queued item is taken and every result has come back.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic random_text(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) add_item(CMD_CHAR, $urandom_range(8'h61, 8'h7a), 0, 0, 0, 0);
      else if (r < 60) add_item(CMD_CHAR, CH_SPACE, $urandom, $urandom, $urandom_range(0, 5) == 0,
                                $urandom);
      else if (r < 68) add_item(CMD_CHAR, ($urandom_range(0, 3) == 0) ? CH_COMMA :
                                ($urandom_range(0, 2) == 0) ? CH_SEMI :
                                ($urandom_range(0, 1) == 0) ? CH_COLON : CH_DOT,
                                0, 0, 0, 0);
      else if (r < 72) add_item(CMD_CHAR, CH_TAB, 0, 0, $urandom, $urandom);
      else if (r < 80) add_item(CMD_CHAR, $urandom_range(0, 31), $urandom, $urandom,
                                $urandom, $urandom);
      else if (r < 86) add_item(CMD_CHAR, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 95) add_item(CMD_HINT, $urandom, $urandom_range(0, 31), $urandom,
                                $urandom, $urandom);
      else if (r < 98) add_item(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom, $urandom);
      else add_item(CMD_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: punctuation weights, attribute value, hints, escapes, command 3.
    write_reg(REG_LIMIT, 8'd12);
    add_text("ab, cd; ef");
    add_item(CMD_CHAR, CH_SPACE, 0, 0, 0, 1);
    add_text("x: y. z");
    add_item(CMD_HINT, 0, 5'd20, 1, 0, 0);
    add_item(CMD_HINT, 0, 5'd31, 0, 0, 0);
    add_item(CMD_HINT, 0, 5'd0, 0, 0, 0);
    add_item(CMD_CHAR, CH_TAB, 0, 0, 1, 0);
    add_item(CMD_CHAR, CH_NL, 0, 0, 0, 0);
    add_item(CMD_FLUSH, 0, 0, 0, 0, 0);
    add_item(CMD_NONE, 8'hff, 5'h1f, 1, 1, 1);
    add_item(CMD_CHAR, 8'hff, 0, 0, 0, 0);
    add_item(CMD_FLUSH, 0, 0, 0, 0, 0);
    drain();

    write_reg(REG_ESCAPE, 8'd1);
    write_reg(REG_NBSP, 8'd3);
    write_reg(REG_ENSP, 8'd31);
    write_reg(REG_SHY, 8'd0);
    write_reg(REG_LIMIT, 8'd0);
    add_item(CMD_CHAR, 8'd3, 0, 0, 0, 0);
    add_item(CMD_CHAR, 8'd31, 0, 0, 0, 0);
    add_item(CMD_CHAR, 8'd0, 0, 0, 0, 0);
    add_item(CMD_FLUSH, 0, 0, 0, 0, 0);
    drain();

    // Random phases under different settings.
    write_reg(REG_LIMIT, 8'd255);
    random_text(70);
    drain();
    write_reg(REG_LIMIT, 8'd20);
    write_reg(REG_ESCAPE, 8'd0);
    random_text(80);
    while (pending_items.size() > 60) @(posedge clk);
    hold_input = 1'b1;
    while (in_valid || expected_words.size() > 0) @(posedge clk);
    hold_input = 1'b0;
    drain();
    write_reg(REG_LIMIT, 8'd198);
    write_reg(REG_NBSP, 8'd1);
    write_reg(REG_ENSP, 8'd2);
    write_reg(REG_SHY, 8'd7);
    write_reg(REG_ESCAPE, 8'd1);
    random_text(60);
    drain();
    write_reg(REG_LIMIT, 8'd1);
    random_text(30);
    drain();
    write_reg(REG_LIMIT, 8'd33);
    random_text(40);
    while (pending_items.size() > 20) @(posedge clk);
    quiet = 1'b1;
    drain();

    if (failures == 0 && expected_words.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
